/* sv/dstt_pkg.sv */
// Shared types, constants and helpers for the decimal seconds to ticks converter.
`default_nettype none

package dstt_pkg;

    localparam int WholeW = 64;
    localparam int FreqW  = 32;
    localparam int FracW  = 10;
    localparam int FdigW  = 2;
    localparam int CharW  = 8;
    localparam int StatW  = 2;
    // frac * freq is below 1000 * 2^32, so 42 bits hold it
    localparam int DivW   = 42;
    localparam int RemW   = 10;
    localparam int CntW   = $clog2(DivW);

    localparam logic [FreqW-1:0] FreqReset     = 32'd10000000;
    localparam logic [CharW-1:0] CharZero      = 8'h30;
    localparam logic [CharW-1:0] CharNine      = 8'h39;
    localparam logic [CharW-1:0] CharDot       = 8'h2e;
    localparam logic [FdigW-1:0] MaxFracDigits = 2'd3;

    localparam logic [StatW-1:0] ST_OK        = 2'd0;
    localparam logic [StatW-1:0] ST_MALFORMED = 2'd1;
    localparam logic [StatW-1:0] ST_ZERO_FREQ = 2'd2;

    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_MUL_LO   = 3'd1;
    localparam logic [2:0] OP_MUL_HI   = 3'd2;
    localparam logic [2:0] OP_MUL_FRAC = 3'd3;
    localparam logic [2:0] OP_DIV_LOAD = 3'd4;
    localparam logic [2:0] OP_DIV_STEP = 3'd5;
    localparam logic [2:0] OP_SUM      = 3'd6;
    localparam logic [2:0] OP_LOAD     = 3'd7;

    typedef struct packed {
        logic       parse;
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic freq_zero;
        logic div_last;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [RemW-1:0] digit_divisor(input logic [FdigW-1:0] fdig);
        logic [RemW-1:0] s;
        case (fdig)
            2'd0: s = 10'd1;
            2'd1: s = 10'd10;
            2'd2: s = 10'd100;
            2'd3: s = 10'd1000;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/dstt_if.sv */
// Valid/ready channel interfaces: character input, result output, frequency write.
`default_nettype none

interface dstt_in_if import dstt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_code;
    logic             last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dstt_out_if import dstt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WholeW-1:0] tick_count;
    logic [WholeW-1:0] secs_int;
    logic [StatW-1:0]  status;
    logic              overflow;

    modport source (output valid, output tick_count, output secs_int,
                    output status, output overflow, input ready);
    modport sink   (input valid, input tick_count, input secs_int,
                    input status, input overflow, output ready);
endinterface

interface dstt_cfg_if import dstt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FreqW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/dstt_datapath.sv */
// Datapath: parse accumulators, shared 32x32 multiplier, serial divider, result register.
`default_nettype none

module dstt_datapath import dstt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic [CharW-1:0]  i_char_code,
    input  wire logic              i_cfg_valid,
    input  wire logic [FreqW-1:0]  i_cfg_data,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [WholeW-1:0]      o_tick_count,
    output logic [WholeW-1:0]      o_secs_int,
    output logic [StatW-1:0]       o_status,
    output logic                   o_overflow
);

    logic [FreqW-1:0]  r_freq;
    logic [WholeW-1:0] r_whole, n_whole;
    logic [FracW-1:0]  r_frac, n_frac;
    logic [FdigW-1:0]  r_fdig, n_fdig;
    logic              r_dot, n_dot;
    logic              r_err, n_err;
    logic              r_wrap, n_wrap;

    logic [WholeW-1:0] r_prod;
    logic [WholeW-1:0] r_hi;
    logic [DivW-1:0]   r_quo;
    logic [RemW-1:0]   r_rem;
    logic [CntW-1:0]   r_cnt;
    logic [WholeW-1:0] r_ticks;
    logic              r_out_valid;

    logic              is_dot, is_digit;
    logic [3:0]        digit;
    logic [WholeW+3:0] whole_x10;
    logic [FreqW-1:0]  mul_a;
    logic [WholeW-1:0] mul_p;
    logic [95:0]       hi_full;
    logic [RemW:0]     trial;
    logic [RemW-1:0]   scale;
    logic              q_bit;
    logic [WholeW:0]   sum_full;

    assign is_dot    = (i_char_code == CharDot);
    assign is_digit  = (i_char_code >= CharZero) && (i_char_code <= CharNine);
    assign digit     = 4'(i_char_code - CharZero);
    assign whole_x10 = ({4'b0, r_whole} << 3) + ({4'b0, r_whole} << 1) + 68'(digit);

    always_comb begin
        case (i_cmd.op)
            OP_MUL_LO: mul_a = r_whole[31:0];
            OP_MUL_HI: mul_a = r_whole[63:32];
            default:   mul_a = {{(FreqW-FracW){1'b0}}, r_frac};
        endcase
    end
    assign mul_p    = mul_a * r_freq;
    assign hi_full  = {32'b0, r_hi} + {r_prod, 32'b0};

    assign scale    = digit_divisor(r_fdig);
    assign trial    = {r_rem, r_quo[DivW-1]};
    assign q_bit    = (trial >= {1'b0, scale});
    assign sum_full = {1'b0, r_hi} + (WholeW+1)'(r_quo);

    always_comb begin
        n_whole = r_whole;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        n_dot   = r_dot;
        n_err   = r_err;
        n_wrap  = r_wrap;
        if (i_cmd.parse && !r_err) begin
            if (is_dot) begin
                if (r_dot) n_err = 1'b1;
                else       n_dot = 1'b1;
            end else if (!is_digit) begin
                n_err = 1'b1;
            end else if (!r_dot) begin
                if (|whole_x10[WholeW+3:WholeW]) n_wrap = 1'b1;
                n_whole = whole_x10[WholeW-1:0];
            end else if (r_fdig == MaxFracDigits) begin
                n_err = 1'b1;
            end else begin
                // at most three digits, so 999 fits
                n_frac = FracW'(({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1)
                                + 14'(digit));
                n_fdig = r_fdig + 2'd1;
            end
        end
        case (i_cmd.op)
            OP_MUL_FRAC: if (|hi_full[95:WholeW]) n_wrap = 1'b1;
            OP_SUM:      if (sum_full[WholeW]) n_wrap = 1'b1;
            OP_LOAD: begin
                n_whole = '0;
                n_frac  = '0;
                n_fdig  = '0;
                n_dot   = 1'b0;
                n_err   = 1'b0;
                n_wrap  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= FreqReset;
            r_whole     <= '0;
            r_frac      <= '0;
            r_fdig      <= '0;
            r_dot       <= 1'b0;
            r_err       <= 1'b0;
            r_wrap      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_freq <= i_cfg_data;
            r_whole <= n_whole;
            r_frac  <= n_frac;
            r_fdig  <= n_fdig;
            r_dot   <= n_dot;
            r_err   <= n_err;
            r_wrap  <= n_wrap;
            if (i_cmd.op == OP_DIV_LOAD)      r_cnt <= '0;
            else if (i_cmd.op == OP_DIV_STEP) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.op == OP_LOAD)  r_out_valid <= 1'b1;
            else if (i_res_ready)     r_out_valid <= 1'b0;
        end
    end

    // arithmetic payload, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MUL_LO: r_prod <= mul_p;
            OP_MUL_HI: begin
                r_hi   <= r_prod;
                r_prod <= mul_p;
            end
            OP_MUL_FRAC: begin
                r_hi   <= hi_full[WholeW-1:0];
                r_prod <= mul_p;
            end
            OP_DIV_LOAD: begin
                r_quo <= r_prod[DivW-1:0];
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_quo <= {r_quo[DivW-2:0], q_bit};
                r_rem <= q_bit ? RemW'(trial - {1'b0, scale}) : trial[RemW-1:0];
            end
            OP_SUM: r_ticks <= sum_full[WholeW-1:0];
            OP_LOAD: begin
                if (r_freq == '0) begin
                    o_status     <= ST_ZERO_FREQ;
                    o_tick_count <= '0;
                    o_secs_int   <= '0;
                    o_overflow   <= 1'b0;
                end else if (r_err) begin
                    o_status     <= ST_MALFORMED;
                    o_tick_count <= '0;
                    o_secs_int   <= '0;
                    o_overflow   <= 1'b0;
                end else begin
                    o_status     <= ST_OK;
                    o_tick_count <= r_ticks;
                    o_secs_int   <= r_whole;
                    o_overflow   <= r_wrap;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid      = r_out_valid;
    assign o_stat.err       = r_err;
    assign o_stat.freq_zero = (r_freq == '0);
    assign o_stat.div_last  = (r_cnt == CntW'(DivW - 1));
    assign o_stat.out_busy  = r_out_valid && !i_res_ready;

    a_cnt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_STEP && !o_stat.div_last) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("divider step count did not advance");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> (r_out_valid && $stable(o_tick_count)))
        else $error("pending result changed");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |=> (!r_err && !r_dot && r_fdig == '0 && !r_wrap))
        else $error("parse state not cleared after result");

endmodule

`default_nettype wire

/* sv/dstt_ctrl.sv */
// Controller: sequences character parsing, multiply, divide, sum and result load.
`default_nettype none

module dstt_ctrl import dstt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_MUL_LO   = 4'd2;
    localparam logic [3:0] S_MUL_HI   = 4'd3;
    localparam logic [3:0] S_MUL_FRAC = 4'd4;
    localparam logic [3:0] S_DIV_LOAD = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_SUM      = 4'd7;
    localparam logic [3:0] S_LOAD     = 4'd8;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd.parse = 1'b0;
        o_cmd.op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_cmd.parse = accept;
                if (accept && i_in_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.err || i_stat.freq_zero) n_state = S_LOAD;
                else                                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_MUL_FRAC;
            end
            S_MUL_FRAC: begin
                o_cmd.op = OP_MUL_FRAC;
                n_state  = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                o_cmd.op = OP_DIV_LOAD;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                // wait for the output register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> (r_state == S_CHECK))
        else $error("final character beat did not start conversion");
    a_err_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && (i_stat.err || i_stat.freq_zero)) |=> (r_state == S_LOAD))
        else $error("error string entered arithmetic");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_last) |=> (r_state == S_SUM))
        else $error("divider did not finish");
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !i_stat.out_busy) |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

endmodule

`default_nettype wire

/* sv/decimal_seconds_to_ticks.sv */
// Decimal seconds string to timer ticks converter, top level.
// Flow: after the final character beat the string is checked; an error goes straight to the
//   result load, else 3 multiply passes, a 42-step divider and a sum come before the load.
// Throughput: one character per cycle within a string; after a final beat no new beat is
//   taken until the result is loaded, and the load waits while a pending result is stalled.
// Reset (synchronous, active low): parse state cleared, no result pending, frequency 10000000.
`default_nettype none

module decimal_seconds_to_ticks import dstt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dstt_in_if.sink     i_in,
    dstt_cfg_if.sink    i_cfg,
    dstt_out_if.source  o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    dstt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_char),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dstt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_char_code  (i_in.char_code),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .o_tick_count (o_res.tick_count),
        .o_secs_int   (o_res.secs_int),
        .o_status     (o_res.status),
        .o_overflow   (o_res.overflow)
    );

endmodule

`default_nettype wire
